### rtl/core/ctd_pkg.sv
`default_nettype none

package ctd_pkg;

    // Field widths
    localparam int CH_W      = 4;
    localparam int COUNT_W   = 16;
    localparam int MASK_W    = 16;
    localparam int SUM_W     = 20;
    localparam int SCANS_W   = 4;
    localparam int MARGIN_W  = 16;

    // Constant divide: q = (sum * recip) >> DIV_SHIFT, exact for sum < 2^SUM_W
    localparam int DIV_SHIFT = SUM_W + SCANS_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TOUCH_MARGIN = 1'b0;   // register index, taken from paddr[2]
    localparam logic [MARGIN_W-1:0] TOUCH_MARGIN_RST = 16'd3;

    // One word on its way from the input register to the result register
    typedef struct packed {
        logic               fire;
        logic               in_range;
        logic               done;
        logic [CH_W-1:0]    ch;
        logic [COUNT_W-1:0] cnt;
    } ctd_step_t;

    // Result word
    typedef struct packed {
        logic              touched;
        logic [MASK_W-1:0] button_mask;
        logic              scan_done;
        logic              calibrating;
    } ctd_result_t;

endpackage

`default_nettype wire

### rtl/core/charge_time_touch_detector.sv
// A word accepted into the input register moves to the result register, which drives m_*.
// Throughput: one word per cycle; the input register and the result register
// both advance while the result side is ready.
// Reset clears the calibration sums, scan counter and button mask, and sets
// touch_margin to 3; no clearing pass, the block accepts words right after reset.
`default_nettype none

module charge_time_touch_detector
    import ctd_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int CAL_SCANS    = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [COUNT_W-1:0]    s_tdata,   // [15:0] charge_count
    input  wire logic [CH_W-1:0]       s_tuser,   // [3:0] channel

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [MASK_W-1:0]     m_tdata,   // [15:0] button_mask
    output logic                       m_tlast,   // scan_done
    output logic      [1:0]            m_tuser    // [0] touched, [1] calibrating
);

    logic [MARGIN_W-1:0] touch_margin_reg;
    logic                cfg_wr;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [CH_W-1:0]     in_chan_reg;
    logic [COUNT_W-1:0]  in_count_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    ctd_result_t         out_res_reg;

    logic                move;
    logic                s_take;
    ctd_step_t           step;
    logic                calibrating;
    logic [COUNT_W-1:0]  baseline;
    ctd_result_t         result;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOUCH_MARGIN);
    assign prdata = (paddr[2] == REG_TOUCH_MARGIN) ? APB_DATA_W'(touch_margin_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_margin_reg <= TOUCH_MARGIN_RST;
        end
        else if (cfg_wr)
        begin
            touch_margin_reg <= pwdata[MARGIN_W-1:0];
        end
    end

    // Handshake: word moves from input register to result register
    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take ? 1'b1 : (move ? 1'b0 : in_valid_reg);
    assign out_valid_next = move ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_chan_reg  <= s_tuser;
            in_count_reg <= s_tdata;
        end
        if (move)
        begin
            out_res_reg <= result;
        end
    end

    // Step decode
    always_comb
    begin
        step.fire     = move;
        step.in_range = ((CH_W+1)'(in_chan_reg) < (CH_W+1)'(NUM_CHANNELS));
        step.done     = step.in_range &&
                        ((CH_W+1)'(in_chan_reg) == (CH_W+1)'(NUM_CHANNELS - 1));
        step.ch       = in_chan_reg;
        step.cnt      = in_count_reg;
    end

    ctd_baseline #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CAL_SCANS    (CAL_SCANS)
    ) u_baseline (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .calibrating (calibrating),
        .baseline    (baseline)
    );

    ctd_detect u_detect (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .calibrating  (calibrating),
        .baseline     (baseline),
        .touch_margin (touch_margin_reg),
        .result       (result)
    );

    // Output side
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_res_reg.button_mask;
    assign m_tlast    = out_res_reg.scan_done;
    assign m_tuser[0] = out_res_reg.touched;
    assign m_tuser[1] = out_res_reg.calibrating;

    // No touch is reported while calibrating
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("touch reported during calibration");

    // Mask stays clear during calibration
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0))
        else $error("button mask set during calibration");

endmodule

`default_nettype wire

### rtl/core/ctd_baseline.sv
`default_nettype none

module ctd_baseline
    import ctd_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int CAL_SCANS    = 10
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctd_step_t          step,
    output logic                    calibrating,
    output logic [COUNT_W-1:0]      baseline
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SCANS) - 64'd1) / 64'(CAL_SCANS));

    logic [SUM_W-1:0]         cal_sum_reg [NUM_CHANNELS];
    logic [SCANS_W-1:0]       scans_reg;
    logic [IDX_W-1:0]         idx;
    logic [SUM_W-1:0]         sum_rd;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W+RECIP_W-1:0] product;
    logic [SUM_W-1:0]         quot;

    assign calibrating = (scans_reg < SCANS_W'(CAL_SCANS));

    // Channel read port; out-of-range channels park on entry 0
    assign idx    = step.in_range ? step.ch[IDX_W-1:0] : '0;
    assign sum_rd = cal_sum_reg[idx];

    // Saturating accumulate
    assign sum_add  = (SUM_W+1)'(sum_rd) + (SUM_W+1)'(step.cnt);
    assign sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    // Baseline = sum / CAL_SCANS, saturated to count width.
    // Sums freeze once calibration ends, so the quotient is taken on read.
    assign product  = (SUM_W+RECIP_W)'(sum_rd) * (SUM_W+RECIP_W)'(RECIP);
    assign quot     = product[DIV_SHIFT +: SUM_W];
    assign baseline = (|quot[SUM_W-1:COUNT_W]) ? '1 : quot[COUNT_W-1:0];

    // Sum store and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cal_sum_reg[i] <= '0;
            end
            scans_reg <= '0;
        end
        else if (step.fire && step.in_range && calibrating)
        begin
            cal_sum_reg[idx] <= sum_next;
            if (step.done)
            begin
                scans_reg <= scans_reg + SCANS_W'(1);
            end
        end
    end

    // Counter never passes the calibration length
    assert property (@(posedge clk) disable iff (!rst_n)
        scans_reg <= SCANS_W'(CAL_SCANS))
        else $error("scan counter ran past calibration length");

    // Calibration ends once and for all
    assert property (@(posedge clk) disable iff (!rst_n)
        !calibrating |=> !calibrating)
        else $error("calibration restarted");

endmodule

`default_nettype wire

### rtl/core/ctd_detect.sv
`default_nettype none

module ctd_detect
    import ctd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctd_step_t           step,
    input  wire logic                calibrating,
    input  wire logic [COUNT_W-1:0]  baseline,
    input  wire logic [MARGIN_W-1:0] touch_margin,
    output ctd_result_t              result
);

    logic [MASK_W-1:0]  scan_mask_reg;
    logic [MASK_W-1:0]  mask_base;
    logic [MASK_W-1:0]  scan_mask_next;
    logic [COUNT_W-1:0] diff;
    logic               hit;

    // Channel 0 opens a new scan
    assign mask_base = (step.in_range && (step.ch == '0)) ? '0 : scan_mask_reg;

    // Absolute deviation from the channel baseline
    assign diff = (step.cnt >= baseline) ? (step.cnt - baseline) : (baseline - step.cnt);
    assign hit  = step.in_range && !calibrating && (diff > touch_margin);

    assign scan_mask_next = mask_base | (hit ? (MASK_W'(1) << step.ch) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mask_reg <= '0;
        end
        else if (step.fire)
        begin
            scan_mask_reg <= scan_mask_next;
        end
    end

    // Result word
    always_comb
    begin
        result.touched     = hit;
        result.button_mask = scan_mask_next;
        result.scan_done   = step.done;
        result.calibrating = calibrating;
    end

endmodule

`default_nettype wire

### tb/tb_charge_time_touch_detector.sv
`default_nettype none

module tb_charge_time_touch_detector;
    import ctd_pkg::*;

    localparam int NCH          = 16;
    localparam int CAL_SCANS_N  = 10;
    localparam int HALF_PERIOD  = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 290;
    localparam int NUM_PHASES   = 6;
    localparam logic [APB_ADDR_W-1:0] MARGIN_ADDR = {REG_TOUCH_MARGIN, 2'b00};

    // One directed word and, where it is obvious, the result it must give
    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [COUNT_W-1:0] cnt;
        logic               typed;
        ctd_result_t        want;
    } stim_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [COUNT_W-1:0]    s_tdata  = '0;   // [15:0] charge_count
    logic [CH_W-1:0]       s_tuser  = '0;   // [3:0] channel
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [MASK_W-1:0]     m_tdata;         // [15:0] button_mask
    logic                  m_tlast;         // scan_done
    logic [1:0]            m_tuser;         // [0] touched, [1] calibrating

    // Detector state as the testbench sees it
    logic [COUNT_W-1:0]  base_q [NCH];
    logic [SUM_W-1:0]    cal_acc [NCH];
    logic [SCANS_W-1:0]  scans_seen = '0;
    logic [MASK_W-1:0]   mask_now = '0;
    logic [MARGIN_W-1:0] touch_margin_now = TOUCH_MARGIN_RST;

    ctd_result_t pending_results [$];
    stim_row_t   dir_rows [0:20];

    int          errors = 0;
    int          words_out = 0;
    int unsigned cycles = 0;
    int unsigned rx_cycle = 0;
    int          stall_left = 0;
    bit          hold_req = 1'b0;
    int          burst_left = 0;

    charge_time_touch_detector #(
        .NUM_CHANNELS (NCH),
        .CAL_SCANS    (CAL_SCANS_N)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        for (int i = 0; i < NCH; i++)
        begin
            base_q[i]  = '0;
            cal_acc[i] = '0;
        end
    end

    // Advance the detector by one word and return what it should output
    function automatic ctd_result_t detect_step(input logic [CH_W-1:0] ch,
                                                input logic [COUNT_W-1:0] cnt);
        ctd_result_t r;
        bit          in_cal;
        int unsigned s;
        int unsigned b;
        int unsigned d;
        r = '0;
        in_cal = scans_seen < CAL_SCANS_N;
        r.calibrating = in_cal;
        if (ch < NCH)
        begin
            r.scan_done = (ch == NCH - 1);
            if (ch == 0)
                mask_now = '0;
            if (in_cal)
            begin
                // sums saturate; the last calibration scan fixes the baselines
                s = cal_acc[ch] + cnt;
                cal_acc[ch] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
                if (r.scan_done)
                begin
                    scans_seen = scans_seen + 1'b1;
                    if (scans_seen >= CAL_SCANS_N)
                        for (int i = 0; i < NCH; i++)
                        begin
                            b = cal_acc[i] / CAL_SCANS_N;
                            base_q[i] = (b > 16'hFFFF) ? 16'hFFFF : b[COUNT_W-1:0];
                        end
                end
            end
            else
            begin
                b = base_q[ch];
                d = (cnt >= b) ? cnt - b : b - cnt;
                if (d > touch_margin_now)
                begin
                    r.touched = 1'b1;
                    mask_now[ch] = 1'b1;
                end
            end
        end
        r.button_mask = mask_now;
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp16(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return v[COUNT_W-1:0];
    endfunction

    // Counts aimed at the touch threshold of a channel, with some full-range noise
    function automatic logic [COUNT_W-1:0] pick_count(input int ch);
        int b;
        int m;
        b = int'(base_q[ch]);
        m = int'(touch_margin_now);
        case ($urandom_range(0, 9))
            0, 1:    return COUNT_W'($urandom_range(0, 65535));
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3:       return clamp16(b);
            4:       return clamp16(b + m);
            5:       return clamp16(b - m);
            6:       return clamp16(b + m + 1);
            7:       return clamp16(b - m - 1);
            default: return clamp16(b + int'($urandom_range(0, 2 * m + 4)) - (m + 2));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // Offer one word in bursts with random gaps; log its result once taken
    task automatic push_word(input logic [CH_W-1:0] ch, input logic [COUNT_W-1:0] cnt,
                             input logic typed, input ctd_result_t want);
        ctd_result_t r;
        int          gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= cnt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = detect_step(ch, cnt);
        pending_results.push_back(typed ? want : r);
        burst_left--;
    endtask

    task automatic stop_words();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            flag_error($sformatf("register read at %0h: want %08h got %08h", addr, want, got));
    endtask

    // Upper data bits are junk; the register keeps the low 16
    task automatic set_touch_margin(input logic [MARGIN_W-1:0] value);
        apb_write(MARGIN_ADDR, {16'($urandom), value});
        touch_margin_now = value;
        apb_read_check(MARGIN_ADDR, {16'h0000, value});
    endtask

    // Result side: compare each word with the oldest expectation
    always @(posedge clk)
    begin
        ctd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("word %0d: result with nothing expected", words_out));
            else
            begin
                want = pending_results.pop_front();
                if (want.touched !== m_tuser[0] || want.button_mask !== m_tdata ||
                    want.scan_done !== m_tlast || want.calibrating !== m_tuser[1])
                    flag_error($sformatf(
                        "word %0d: want t%0b m%04h d%0b c%0b, got t%0b m%04h d%0b c%0b",
                        words_out, want.touched, want.button_mask, want.scan_done,
                        want.calibrating, m_tuser[0], m_tdata, m_tlast, m_tuser[1]));
            end
            words_out++;
        end
    end

    // Receiver stalls: rotating patterns, plus one long hold-off on request
    always @(negedge clk)
    begin
        rx_cycle++;
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_cycle % 3 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int unsigned nom [NCH];
        int unsigned phase_margin [NUM_PHASES];
        bit          sat_done;
        int          n;
        int          j;

        // Calibration words: every field extreme, out-of-order channels,
        // scans closed by channel 15 without a channel 0
        dir_rows = '{
            '{4'd0,  16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd1,  16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd2,  16'h0001, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd3,  16'hFFFE, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd4,  16'h5555, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd5,  16'hAAAA, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd6,  16'h00FF, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd7,  16'hFF00, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd8,  16'h0F0F, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd9,  16'hF0F0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd10, 16'h3333, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd11, 16'hCCCC, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd12, 16'h8000, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd13, 16'h7FFF, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd14, 16'h0001, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd15, 16'hFFFE, 1'b1, '{1'b0, 16'h0000, 1'b1, 1'b1}},
            '{4'd3,  16'h1234, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd15, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b1, 1'b1}},
            '{4'd0,  16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd0,  16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b1}},
            '{4'd15, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b1, 1'b1}}
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        apb_read_check(MARGIN_ADDR, 32'(TOUCH_MARGIN_RST));

        foreach (dir_rows[i])
            push_word(dir_rows[i].ch, dir_rows[i].cnt, dir_rows[i].typed, dir_rows[i].want);

        // Rest of calibration: steady counts per channel; one channel is
        // repeated at full scale until its sum and baseline saturate
        for (int k = 0; k < NCH; k++)
            nom[k] = $urandom_range(0, 65535);
        nom[2]  = 0;
        nom[12] = 65535;
        sat_done = 1'b0;
        while (scans_seen < CAL_SCANS_N)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                push_word(CH_W'(k), clamp16(int'(nom[k]) + int'($urandom_range(0, 40)) - 20),
                          1'b0, '0);
                if (k == 9 && !sat_done)
                begin
                    repeat (20) push_word(4'd9, 16'hFFFF, 1'b0, '0);
                    sat_done = 1'b1;
                end
            end
        end
        stop_words();

        // Detection phases at several margins; the first keeps the reset value
        phase_margin = '{3, 0, 65535, 1, 0, 200};
        phase_margin[4] = $urandom_range(2, 4000);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            while (pending_results.size() != 0)
                @(posedge clk);
            if (p != 0)
                set_touch_margin(MARGIN_W'(phase_margin[p]));
            if (p == 1)
                hold_req = 1'b1;
            n = 0;
            while (n < PHASE_WORDS)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    for (int k = 0; k < NCH; k++)
                        push_word(CH_W'(k), pick_count(k), 1'b0, '0);
                    n += NCH;
                end
                else
                begin
                    j = $urandom_range(1, 6);
                    repeat (j)
                    begin
                        push_word(CH_W'($urandom_range(0, NCH - 1)),
                                  COUNT_W'($urandom_range(0, 65535)), 1'b0, '0);
                        n++;
                    end
                end
            end
            stop_words();
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
